// ===== design/ir_pulse_width_capture_defines.svh =====
// Assertion macros of the infrared pulse width capture design.
`ifndef IR_PULSE_WIDTH_CAPTURE_DEFINES_SVH
`define IR_PULSE_WIDTH_CAPTURE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define IR_PWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define IR_PWC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== design/ir_pwc_pkg.sv =====
// Package with the codes, types and constants of the infrared pulse width capture.
`timescale 1ns / 1ps
`default_nettype none
package ir_pwc_pkg;

  // Input item operations.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_EDGE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Result item kinds.
  localparam logic KIND_INTERVAL = 1'b0;
  localparam logic KIND_END      = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_SHORT_GAP = 2'd0;
  localparam logic [1:0] REG_LONG_GAP  = 2'd1;
  localparam logic [1:0] REG_MIN_EDGES = 2'd2;
  localparam logic [1:0] REG_TIMEOUT   = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  // Configuration reset values.
  localparam logic [7:0]  RST_SHORT_GAP = 8'd20;
  localparam logic [7:0]  RST_LONG_GAP  = 8'd200;
  localparam logic [7:0]  RST_MIN_EDGES = 8'd10;
  localparam logic [13:0] RST_TIMEOUT   = 14'd10000;

  // Counter and duration limits.
  localparam logic [7:0]  GAP_MAX     = 8'd255;
  localparam logic [13:0] ELAPSED_MAX = 14'd16383;
  localparam logic [15:0] DUR_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  short_gap_ms;
    logic [7:0]  long_gap_ms;
    logic [7:0]  min_edges_short_gap;
    logic [13:0] capture_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [6:0]  interval_index;
    logic [15:0] duration_us;
    logic        is_mark;
    logic        status;
    logic [7:0]  interval_count;
  } res_t;

endpackage
`default_nettype wire

// ===== design/ir_pwc_cfg.sv =====
// Configuration register file of the infrared pulse width capture.
`timescale 1ns / 1ps
`default_nettype none
module ir_pwc_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [ir_pwc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ir_pwc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output ir_pwc_pkg::cfg_t                      cfg_o
);

  ir_pwc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ir_pwc_pkg::REG_SHORT_GAP: cfg_d.short_gap_ms        = cfg_wdata_i[7:0];
        ir_pwc_pkg::REG_LONG_GAP:  cfg_d.long_gap_ms         = cfg_wdata_i[7:0];
        ir_pwc_pkg::REG_MIN_EDGES: cfg_d.min_edges_short_gap = cfg_wdata_i[7:0];
        ir_pwc_pkg::REG_TIMEOUT:   cfg_d.capture_timeout_ms  = cfg_wdata_i[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_gap_ms        <= ir_pwc_pkg::RST_SHORT_GAP;
      cfg_q.long_gap_ms         <= ir_pwc_pkg::RST_LONG_GAP;
      cfg_q.min_edges_short_gap <= ir_pwc_pkg::RST_MIN_EDGES;
      cfg_q.capture_timeout_ms  <= ir_pwc_pkg::RST_TIMEOUT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== design/ir_pwc_us_conv.sv =====
// Converter from a 32-bit clock count to saturated microseconds.
`timescale 1ns / 1ps
`default_nettype none
module ir_pwc_us_conv #(
  parameter int CLOCKS_PER_US = 40
) (
  input  wire logic [31:0] delta_i,
  output logic      [15:0] us_o
);

  // Below the saturation limit the count fits in X_W bits, and a reciprocal
  // with X_W + 1 bits and a shift of X_W + LOG_C gives the exact quotient.
  localparam int LOG_C = $clog2(CLOCKS_PER_US);
  localparam int X_W   = 16 + LOG_C;
  localparam int SHIFT = X_W + LOG_C;
  localparam int M_W   = X_W + 1;
  localparam int P_W   = X_W + M_W;
  localparam logic [63:0] RECIP =
      ((64'd1 << SHIFT) + 64'(CLOCKS_PER_US) - 64'd1) / 64'(CLOCKS_PER_US);
  localparam logic [31:0] SAT_LIM = 32'(65536 * CLOCKS_PER_US);

  logic [X_W-1:0] x;
  logic [M_W-1:0] recip;
  logic [P_W-1:0] prod;
  logic           sat;

  assign x     = delta_i[X_W-1:0];
  assign recip = RECIP[M_W-1:0];
  assign prod  = P_W'(x) * P_W'(recip);
  assign sat   = (delta_i >= SAT_LIM);
  assign us_o  = sat ? ir_pwc_pkg::DUR_MAX : prod[SHIFT +: 16];

endmodule
`default_nettype wire

// ===== design/ir_pwc_core.sv =====
// Capture state and per-item decision logic of the infrared pulse width capture.
`timescale 1ns / 1ps
`default_nettype none
`include "ir_pulse_width_capture_defines.svh"
module ir_pwc_core #(
  parameter int MAX_INTERVALS = 128,
  parameter int CLOCKS_PER_US = 40
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ir_pwc_pkg::cfg_t  cfg_i,
  input  wire logic              advance_i,
  input  wire logic [1:0]        op_i,
  input  wire logic              level_i,
  input  wire logic [31:0]       ts_i,
  output logic                   has_result_o,
  output ir_pwc_pkg::res_t       res_o
);

  // The edge counter holds up to MAX_INTERVALS + 1 (opening edge included).
  localparam int EW = $clog2(MAX_INTERVALS + 2);
  localparam logic [EW-1:0] MAX_EDGE = EW'(MAX_INTERVALS);
  localparam logic [EW-1:0] EDGE_ONE = EW'(1);
  localparam logic [EW-1:0] EDGE_TOP = EW'(MAX_INTERVALS + 1);

  logic          active_q, active_d;
  logic [EW-1:0] edge_q, edge_d;
  logic [31:0]   last_q, last_d;
  logic [7:0]    gap_q, gap_d;
  logic [13:0]   elapsed_q, elapsed_d;

  logic [31:0]   delta;
  logic [15:0]   dur_us;
  logic [7:0]    gap_inc;
  logic [13:0]   elapsed_inc;
  logic [EW-1:0] idx;
  logic [EW-1:0] n_int;
  logic [31:0]   idx_ext;
  logic [31:0]   n_ext;
  logic          enough_edges;

  assign delta       = last_q - ts_i;
  assign gap_inc     = (gap_q == ir_pwc_pkg::GAP_MAX) ? gap_q : gap_q + 8'd1;
  assign elapsed_inc = (elapsed_q == ir_pwc_pkg::ELAPSED_MAX) ? elapsed_q
                                                               : elapsed_q + 14'd1;
  assign idx          = edge_q - EDGE_ONE;
  assign n_int        = (edge_q != '0) ? idx : '0;
  assign idx_ext      = 32'(idx);
  assign n_ext        = 32'(n_int);
  assign enough_edges = (32'(edge_q) >= 32'(cfg_i.min_edges_short_gap));

  ir_pwc_us_conv #(
    .CLOCKS_PER_US(CLOCKS_PER_US)
  ) u_us_conv (
    .delta_i(delta),
    .us_o   (dur_us)
  );

  always_comb begin
    logic end_frame;
    logic timed_out;
    end_frame    = 1'b0;
    timed_out    = 1'b0;
    active_d     = active_q;
    edge_d       = edge_q;
    last_d       = last_q;
    gap_d        = gap_q;
    elapsed_d    = elapsed_q;
    has_result_o = 1'b0;
    res_o        = '0;
    case (op_i)
      ir_pwc_pkg::OP_START: begin
        edge_d    = '0;
        gap_d     = '0;
        elapsed_d = '0;
        active_d  = 1'b1;
      end
      ir_pwc_pkg::OP_EDGE: begin
        if (active_q) begin
          gap_d = '0;
          if (edge_q == '0) begin
            if (!level_i) begin
              last_d = ts_i;
              edge_d = EDGE_ONE;
            end
          end else begin
            last_d = ts_i;
            if (edge_q <= MAX_EDGE) begin
              edge_d               = edge_q + EDGE_ONE;
              has_result_o         = 1'b1;
              res_o.kind           = ir_pwc_pkg::KIND_INTERVAL;
              res_o.interval_index = idx_ext[6:0];
              res_o.duration_us    = dur_us;
              res_o.is_mark        = ~idx[0];
            end else begin
              // Buffer full: this edge closes the frame instead.
              end_frame = 1'b1;
            end
          end
        end
      end
      ir_pwc_pkg::OP_TICK: begin
        elapsed_d = elapsed_inc;
        if (active_q) begin
          if (edge_q > EDGE_ONE) begin
            gap_d = gap_inc;
            if ((enough_edges && (gap_inc >= cfg_i.short_gap_ms)) ||
                (gap_inc >= cfg_i.long_gap_ms)) begin
              end_frame = 1'b1;
            end
          end
          if (!end_frame && (elapsed_inc >= cfg_i.capture_timeout_ms)) begin
            end_frame = 1'b1;
            timed_out = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (end_frame) begin
      active_d             = 1'b0;
      has_result_o         = 1'b1;
      res_o.kind           = ir_pwc_pkg::KIND_END;
      res_o.status         = timed_out || (n_ext <= 32'd1);
      res_o.interval_count = n_ext[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      edge_q    <= '0;
      last_q    <= '0;
      gap_q     <= '0;
      elapsed_q <= '0;
    end else if (advance_i) begin
      active_q  <= active_d;
      edge_q    <= edge_d;
      last_q    <= last_d;
      gap_q     <= gap_d;
      elapsed_q <= elapsed_d;
    end
  end

  `IR_PWC_NEVER(a_edge_limit, edge_q > EDGE_TOP, "edge counter passed its limit")
  `IR_PWC_ASSERT(a_gap_idle, (active_q && (edge_q <= EDGE_ONE)) |-> (gap_q == '0), "gap counted before the second edge")
  `IR_PWC_ASSERT(a_end_stops, (advance_i && has_result_o && (res_o.kind == ir_pwc_pkg::KIND_END)) |=> !active_q, "capture still active after frame end")

endmodule
`default_nettype wire

// ===== design/ir_pulse_width_capture.sv =====
// Top level of the infrared pulse width capture with its stream registers.
`timescale 1ns / 1ps
`default_nettype none
// Infrared raw timing capture. A start item arms the capture; edge items carry
// the receiver pin level and a down-counting timestamp at CLOCKS_PER_US counts
// per microsecond; tick items mark one millisecond each. The first falling
// edge opens a frame and every later edge yields one interval item holding
// its index, its length in microseconds (saturated to 65535) and whether it
// is a mark. The frame closes with one end item on a short gap after enough
// edges, on a long gap, when MAX_INTERVALS intervals are already stored, or
// on the overall timeout; its status is zero only when more than one
// interval was recorded. The block takes one item per clock cycle while the
// result stream does not stall. Each item passes through an input register,
// one pass of decision logic with the microsecond converter (a single
// reciprocal multiplier), and the result register, which offers its result.
// Items that cause no result pass even while a result waits downstream.
module ir_pulse_width_capture #(
  parameter int MAX_INTERVALS = 128,
  parameter int CLOCKS_PER_US = 40
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Input stream.
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata fields from bit 0: pin_level (1), timestamp (32), zero fill (7).
  input  wire logic [39:0]                      s_axis_tdata,
  // tuser fields from bit 0: op (2).
  input  wire logic [1:0]                       s_axis_tuser,
  // Result stream.
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // tdata fields from bit 0: interval_index (7), duration_us (16), is_mark (1),
  // status (1), interval_count (8), zero fill (7).
  output logic      [39:0]                      m_axis_tdata,
  // tuser fields from bit 0: kind (1).
  output logic      [0:0]                       m_axis_tuser,
  // Configuration write port.
  input  wire logic                             cfg_we_i,
  input  wire logic [ir_pwc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ir_pwc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  ir_pwc_pkg::cfg_t cfg;
  ir_pwc_pkg::res_t res;
  ir_pwc_pkg::res_t out_q;

  logic        in_valid_q, in_valid_d;
  logic [1:0]  in_op_q;
  logic        in_level_q;
  logic [31:0] in_ts_q;
  logic        out_valid_q, out_valid_d;
  logic        has_result;
  logic        advance;
  logic        s_accept;

  ir_pwc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  ir_pwc_core #(
    .MAX_INTERVALS(MAX_INTERVALS),
    .CLOCKS_PER_US(CLOCKS_PER_US)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .advance_i   (advance),
    .op_i        (in_op_q),
    .level_i     (in_level_q),
    .ts_i        (in_ts_q),
    .has_result_o(has_result),
    .res_o       (res)
  );

  // The held item moves on when its result has a free slot, or when it
  // causes no result at all.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready || !has_result);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = (advance && has_result) ? 1'b1
                                               : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_op_q    <= s_axis_tuser;
      in_level_q <= s_axis_tdata[0];
      in_ts_q    <= s_axis_tdata[32:1];
    end
    if (advance && has_result) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {7'd0, out_q.interval_count, out_q.status, out_q.is_mark,
                          out_q.duration_us, out_q.interval_index};

endmodule
`default_nettype wire
